// File: hw/rtl/ppf_pkg.sv
// Shared widths, register indexes, reset values and word type for the palindromic prime filter.
package ppf_pkg;

    // Field widths
    localparam int IDX_W     = 14;
    localparam int VAL_W     = 24;
    localparam int CFG_W     = 27;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LOWER = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER = 2'd1;

    // Configuration reset values
    localparam logic [CFG_W-1:0] LOWER_RESET = 27'd0;
    localparam logic [CFG_W-1:0] UPPER_RESET = 27'd100000000;

    typedef logic [VAL_W-1:0] t_val;
    typedef logic [CFG_W-1:0] t_cfg;

    // One candidate word travelling between front, queue and back
    typedef struct packed {
        logic valid;
        t_val value;
    } t_word;

endpackage

// File: hw/rtl/palindromic_prime_filter.sv
// Top level: configuration registers, front, word queue and trial-division back.
//
//  channel   signals                                  handshake
//  -------   ---------------------------------------  -------------------------------
//  input     i_candidate_index                        taken when start && !busy
//  result    o_prime_value                            valid for one cycle on o_strobe
//  config    i_cfg_index, i_cfg_wdata                 written when i_cfg_we is high
//
//  The front holds one index at a time; busy is high while it holds an index or the
//  queue is full. The back tries the odd divisors d from 3 up with d*d <= value, then
//  drains its remainder pipe before it reports; a composite stops once its smallest
//  factor is found.
//  Reset is synchronous and clears all control state and loads the bound reset values.
//  The receiver cannot stall: each result is shown for exactly one cycle.
module palindromic_prime_filter #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [ppf_pkg::IDX_W-1:0]      i_candidate_index,
    output logic                           o_strobe,
    output logic [ppf_pkg::VAL_W-1:0]      o_prime_value,
    input  logic                           i_cfg_we,
    input  logic [ppf_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ppf_pkg::CFG_W-1:0]      i_cfg_wdata
);

    ppf_pkg::t_cfg  r_lower_bound;
    ppf_pkg::t_cfg  r_upper_bound;
    ppf_pkg::t_word push_word;
    ppf_pkg::t_word head_word;
    logic           front_active;
    logic           queue_full;
    logic           pop;

    // Write the bound registers, ignore other indexes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower_bound <= ppf_pkg::LOWER_RESET;
            r_upper_bound <= ppf_pkg::UPPER_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ppf_pkg::REG_LOWER: r_lower_bound <= i_cfg_wdata;
                ppf_pkg::REG_UPPER: r_upper_bound <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign busy = front_active || queue_full;

    ppf_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_accept          (start && !busy),
        .i_candidate_index (i_candidate_index),
        .i_lower_bound     (r_lower_bound),
        .i_upper_bound     (r_upper_bound),
        .o_push            (push_word),
        .o_active          (front_active)
    );

    ppf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push_word),
        .i_pop   (pop),
        .o_head  (head_word),
        .o_full  (queue_full)
    );

    ppf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_word),
        .o_pop         (pop),
        .o_strobe      (o_strobe),
        .o_prime_value (o_prime_value)
    );

endmodule

// File: hw/rtl/ppf_front.sv
// Front part: forms the palindrome for an index, checks bounds and parity, pushes survivors.
module ppf_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [ppf_pkg::IDX_W-1:0]  i_candidate_index,
    input  ppf_pkg::t_cfg              i_lower_bound,
    input  ppf_pkg::t_cfg              i_upper_bound,
    output ppf_pkg::t_word             o_push,
    output logic                       o_active
);

    // Palindrome classes
    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_LIT   = 3'd1;
    localparam logic [2:0] KIND_THREE = 3'd2;
    localparam logic [2:0] KIND_FIVE  = 3'd3;
    localparam logic [2:0] KIND_SEVEN = 3'd4;

    localparam logic [13:0] LAST_INDEX = 14'd9992;
    localparam logic [13:0] BASE_THREE = 14'd3;
    localparam logic [13:0] BASE_FIVE  = 14'd93;
    localparam logic [13:0] BASE_SEVEN = 14'd993;

    // Reciprocal multipliers: x/10 for x < 43699, x/10 for x < 1029, x/100 for x < 1000
    localparam logic [15:0] RECIP10_WIDE = 16'd52429;
    localparam logic [7:0]  RECIP10_NARW = 8'd205;
    localparam logic [5:0]  RECIP100     = 6'd41;

    // Stage A: index
    logic                       r_a_valid;
    logic [ppf_pkg::IDX_W-1:0]  r_idx;
    // Stage B: class, prefix quotient, middle digit
    logic                       r_b_valid;
    logic [2:0]                 r_b_kind;
    logic [9:0]                 r_q;
    logic [3:0]                 r_b_mid;
    // Stage C: prefix, middle digit, reversed prefix
    logic                       r_c_valid;
    logic [2:0]                 r_c_kind;
    logic [9:0]                 r_pre;
    logic [3:0]                 r_c_mid;
    logic [9:0]                 r_rev;
    // Stage D: palindrome value
    logic                       r_d_valid;
    logic                       r_d_keep;
    ppf_pkg::t_val              r_val;

    logic [2:0]  n_kind;
    logic [13:0] base_sel;
    logic [13:0] k_val;
    logic [29:0] q_prod;
    logic [9:0]  q_val;
    logic [13:0] mid_full;
    logic [9:0]  n_pre;
    logic [17:0] t_prod;
    logic [6:0]  t_val10;
    logic [15:0] h_prod;
    logic [3:0]  d2;
    logic [9:0]  d0_full;
    logic [6:0]  d1_full;
    logic [9:0]  n_rev;
    ppf_pkg::t_val n_val;
    logic        in_bounds;

    // Classify the index and split its offset into prefix quotient and middle digit
    always_comb begin
        if (r_idx > LAST_INDEX) begin
            n_kind   = KIND_NONE;
            base_sel = BASE_SEVEN;
        end else if (r_idx < BASE_THREE) begin
            n_kind   = KIND_LIT;
            base_sel = BASE_THREE;
        end else if (r_idx < BASE_FIVE) begin
            n_kind   = KIND_THREE;
            base_sel = BASE_THREE;
        end else if (r_idx < BASE_SEVEN) begin
            n_kind   = KIND_FIVE;
            base_sel = BASE_FIVE;
        end else begin
            n_kind   = KIND_SEVEN;
            base_sel = BASE_SEVEN;
        end
        k_val    = r_idx - base_sel;
        q_prod   = 30'(k_val) * 30'(RECIP10_WIDE);
        q_val    = q_prod[28:19];
        mid_full = k_val - 14'(q_val) * 14'd10;
    end

    // Form the prefix and its reversed digits
    always_comb begin
        unique case (r_b_kind)
            KIND_THREE: n_pre = r_q + 10'd1;
            KIND_FIVE:  n_pre = r_q + 10'd10;
            KIND_SEVEN: n_pre = r_q + 10'd100;
            default:    n_pre = r_q;
        endcase
        t_prod  = 18'(n_pre) * 18'(RECIP10_NARW);
        t_val10 = t_prod[17:11];
        h_prod  = 16'(n_pre) * 16'(RECIP100);
        d2      = h_prod[15:12];
        d0_full = n_pre - 10'(t_val10) * 10'd10;
        d1_full = t_val10 - 7'(d2) * 7'd10;
        if (r_b_kind == KIND_FIVE) begin
            n_rev = 10'(d0_full[3:0]) * 10'd10 + 10'(t_val10);
        end else begin
            n_rev = 10'(d0_full[3:0]) * 10'd100 + 10'(d1_full[3:0]) * 10'd10 + 10'(d2);
        end
    end

    // Assemble the palindrome value
    always_comb begin
        unique case (r_c_kind)
            KIND_THREE: n_val = 24'(r_pre) * 24'd101 + 24'(r_c_mid) * 24'd10;
            KIND_FIVE:  n_val = 24'(r_pre) * 24'd1000 + 24'(r_c_mid) * 24'd100
                                + 24'(r_rev);
            KIND_SEVEN: n_val = 24'(r_pre) * 24'd10000 + 24'(r_c_mid) * 24'd1000
                                + 24'(r_rev);
            KIND_LIT: begin
                unique case (r_pre[1:0])
                    2'd0:    n_val = 24'd5;
                    2'd1:    n_val = 24'd7;
                    default: n_val = 24'd11;
                endcase
            end
            default:    n_val = '0;
        endcase
    end

    // Advance the stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_a_valid <= i_accept;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Advance the stage payloads
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_idx <= i_candidate_index;
        end
        r_b_kind <= n_kind;
        r_q      <= (n_kind == KIND_LIT) ? r_idx[9:0] : q_val;
        r_b_mid  <= mid_full[3:0];
        r_c_kind <= r_b_kind;
        r_pre    <= n_pre;
        r_c_mid  <= r_b_mid;
        r_rev    <= n_rev;
        r_d_keep <= (r_c_kind != KIND_NONE);
        r_val    <= n_val;
    end

    // Drop values outside the bounds, even values and indexes past the last one
    assign in_bounds = (ppf_pkg::CFG_W'(r_val) >= i_lower_bound)
                    && (ppf_pkg::CFG_W'(r_val) <= i_upper_bound);

    assign o_push.valid = r_d_valid && r_d_keep && in_bounds && r_val[0];
    assign o_push.value = r_val;
    assign o_active     = r_a_valid || r_b_valid || r_c_valid || r_d_valid;

endmodule

// File: hw/rtl/ppf_queue.sv
// Short word queue between the front and the back.
module ppf_queue #(
    parameter int DEPTH = 2
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppf_pkg::t_word i_push,
    input  logic           i_pop,
    output ppf_pkg::t_word o_head,
    output logic           o_full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ppf_pkg::t_val     r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;

    logic do_push;
    logic do_pop;

    assign do_push = i_push.valid && !o_full;
    assign do_pop  = i_pop && o_head.valid;

    // Store the pushed word
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_push.value;
        end
    end

    // Advance pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_head.valid = (r_count != '0);
    assign o_head.value = r_mem[r_rd_ptr];
    assign o_full       = (r_count == CNT_W'(DEPTH));

endmodule

// File: hw/rtl/ppf_back.sv
// Back part: trial division of one word by odd divisors through a three-stage remainder pipe.
module ppf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  ppf_pkg::t_word i_head,
    output logic           o_pop,
    output logic           o_strobe,
    output ppf_pkg::t_val  o_prime_value
);

    localparam int DIV_W   = 12;
    localparam int SQ_W    = 25;
    localparam int STEP_W  = 8;
    localparam int NUM_STG = ppf_pkg::VAL_W / STEP_W;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    typedef logic [DIV_W-1:0] t_div;

    // Fold STEP_W more dividend bits into a running remainder
    function automatic t_div rem_step(input t_div rem_in, input t_div d,
                                      input logic [STEP_W-1:0] chunk);
        logic [DIV_W:0] x;
        t_div           r;
        r = rem_in;
        for (int i = STEP_W - 1; i >= 0; i--) begin
            x = {r, chunk[i]};
            if (x >= {1'b0, d}) begin
                x = x - {1'b0, d};
            end
            r = x[DIV_W-1:0];
        end
        return r;
    endfunction

    logic          r_state;
    ppf_pkg::t_val r_v;
    t_div          r_d;
    logic [SQ_W-1:0] r_sq;
    logic          r_issue;
    logic          r_comp;
    logic          r_strobe;
    ppf_pkg::t_val r_prime;

    logic          r_stg_valid [NUM_STG];
    t_div          r_stg_d     [NUM_STG];
    t_div          r_stg_rem   [NUM_STG];

    logic          issue_now;
    logic          found_factor;
    logic          pipe_busy;
    logic          finish;

    always_comb begin
        pipe_busy = 1'b0;
        for (int s = 0; s < NUM_STG; s++) begin
            pipe_busy = pipe_busy || r_stg_valid[s];
        end
    end

    assign issue_now    = (r_state == ST_RUN) && r_issue && !r_comp
                       && (r_sq <= SQ_W'(r_v));
    assign found_factor = r_stg_valid[NUM_STG-1] && (r_stg_rem[NUM_STG-1] == '0);
    assign finish       = (r_state == ST_RUN) && !r_issue && !pipe_busy;
    assign o_pop        = (r_state == ST_IDLE) && i_head.valid;

    // Sequence one word: load, issue divisors, drain, report
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_issue  <= 1'b0;
            r_comp   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= finish && !r_comp;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_head.valid) begin
                        r_state <= ST_RUN;
                        r_issue <= 1'b1;
                        r_comp  <= 1'b0;
                    end
                end
                ST_RUN: begin
                    if (found_factor) begin
                        r_comp <= 1'b1;
                    end
                    if (!issue_now) begin
                        r_issue <= 1'b0;
                    end
                    if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Hold the word and step the divisor and its square
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_v  <= i_head.value;
            r_d  <= DIV_W'(3);
            r_sq <= SQ_W'(9);
        end else if (issue_now) begin
            r_d  <= r_d + DIV_W'(2);
            r_sq <= r_sq + (SQ_W'(r_d) << 2) + SQ_W'(4);
        end
        if (finish) begin
            r_prime <= r_v;
        end
    end

    // Remainder pipe valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < NUM_STG; s++) begin
                r_stg_valid[s] <= 1'b0;
            end
        end else begin
            r_stg_valid[0] <= issue_now;
            for (int s = 1; s < NUM_STG; s++) begin
                r_stg_valid[s] <= r_stg_valid[s-1];
            end
        end
    end

    // Remainder pipe payloads, most significant chunk first
    always_ff @(posedge i_clk) begin
        r_stg_d[0]   <= r_d;
        r_stg_rem[0] <= rem_step('0, r_d, r_v[ppf_pkg::VAL_W-1 -: STEP_W]);
        for (int s = 1; s < NUM_STG; s++) begin
            r_stg_d[s]   <= r_stg_d[s-1];
            r_stg_rem[s] <= rem_step(r_stg_rem[s-1], r_stg_d[s-1],
                                     r_v[ppf_pkg::VAL_W-1-s*STEP_W -: STEP_W]);
        end
    end

    assign o_strobe      = r_strobe;
    assign o_prime_value = r_prime;

endmodule
